// File: rtl/i2ctrb_pkg.sv
// ----------------------------------------------------------------------------
// i2ctrb_pkg
// shared item types and event codes for the i2c target register bank
// ----------------------------------------------------------------------------
package i2ctrb_pkg;

    localparam logic [1:0] KIND_RX_BYTE = 2'd0;
    localparam logic [1:0] KIND_TX_REQ  = 2'd1;
    localparam logic [1:0] KIND_STOP    = 2'd2;
    localparam logic [1:0] KIND_OTHER   = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
    } t_out_item;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic tx_req;
    } t_mem_op;

endpackage

// File: rtl/i2ctrb_ram.sv
// ----------------------------------------------------------------------------
// i2ctrb_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module i2ctrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/i2ctrb_ctrl.sv
// ----------------------------------------------------------------------------
// i2ctrb_ctrl
// target, byte index and store access decode for one bus event per item
// ----------------------------------------------------------------------------
module i2ctrb_ctrl
    import i2ctrb_pkg::*;
#(
    parameter int REG_COUNT     = 128,
    parameter int BYTES_PER_REG = 4,
    parameter int ADDR_W        = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_in_item          i_item,
    output t_mem_op           o_op,
    output logic [ADDR_W-1:0] o_addr,
    output logic [7:0]        o_wdata
);

    localparam int REG_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int IDX_W = (BYTES_PER_REG > 1) ? $clog2(BYTES_PER_REG) : 1;

    logic             r_wr_tgt_vld, n_wr_tgt_vld;
    logic [REG_W-1:0] r_wr_tgt, n_wr_tgt;
    logic             r_rd_tgt_vld, n_rd_tgt_vld;
    logic [REG_W-1:0] r_rd_tgt, n_rd_tgt;
    logic [IDX_W-1:0] r_idx, n_idx;

    logic [REG_W-1:0] reg_lut [128];
    logic [REG_W-1:0] sel_reg;
    logic [REG_W-1:0] acc_reg;
    logic             idx_last;
    logic [IDX_W-1:0] idx_inc;

    // register number modulo bank size, as a constant table
    for (genvar g = 0; g < 128; g++) begin : g_reg_lut
        assign reg_lut[g] = REG_W'(g % REG_COUNT);
    end

    assign sel_reg  = reg_lut[i_item.rx_byte[7:1]];
    assign idx_last = (r_idx == IDX_W'(BYTES_PER_REG - 1));
    assign idx_inc  = idx_last ? '0 : r_idx + IDX_W'(1);
    assign acc_reg  = (i_item.kind == KIND_TX_REQ) ? r_rd_tgt : r_wr_tgt;
    assign o_addr   = ADDR_W'(acc_reg) * ADDR_W'(BYTES_PER_REG) + ADDR_W'(r_idx);
    assign o_wdata  = i_item.rx_byte;

    always_comb begin
        n_wr_tgt_vld = r_wr_tgt_vld;
        n_wr_tgt     = r_wr_tgt;
        n_rd_tgt_vld = r_rd_tgt_vld;
        n_rd_tgt     = r_rd_tgt;
        n_idx        = r_idx;
        o_op         = '0;
        if (i_accept) begin
            case (i_item.kind)
                KIND_RX_BYTE: begin
                    if (!r_wr_tgt_vld) begin
                        if (i_item.rx_byte[0]) begin
                            n_wr_tgt     = sel_reg;
                            n_wr_tgt_vld = 1'b1;
                        end else begin
                            n_rd_tgt     = sel_reg;
                            n_rd_tgt_vld = 1'b1;
                        end
                    end else begin
                        o_op.wr_en = 1'b1;
                        n_idx      = idx_inc;
                        if (idx_last) begin
                            n_wr_tgt_vld = 1'b0;
                        end
                    end
                end
                KIND_TX_REQ: begin
                    o_op.tx_req = 1'b1;
                    if (r_rd_tgt_vld) begin
                        o_op.rd_en = 1'b1;
                        n_idx      = idx_inc;
                    end
                end
                KIND_STOP: begin
                    if (r_idx != '0) begin
                        n_wr_tgt_vld = 1'b0;
                        n_rd_tgt_vld = 1'b0;
                        n_wr_tgt     = '0;
                        n_rd_tgt     = '0;
                        n_idx        = '0;
                    end
                end
                KIND_OTHER: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_tgt_vld <= 1'b0;
            r_wr_tgt     <= '0;
            r_rd_tgt_vld <= 1'b0;
            r_rd_tgt     <= '0;
            r_idx        <= '0;
        end else begin
            r_wr_tgt_vld <= n_wr_tgt_vld;
            r_wr_tgt     <= n_wr_tgt;
            r_rd_tgt_vld <= n_rd_tgt_vld;
            r_rd_tgt     <= n_rd_tgt;
            r_idx        <= n_idx;
        end
    end

endmodule

// File: rtl/i2c_target_register_bank_core.sv
// ----------------------------------------------------------------------------
// i2c_target_register_bank_core
// byte-level i2c target serving a bank of multi-byte registers
// ----------------------------------------------------------------------------
// One bus event is taken per clock cycle while o_in_stall is low. Its result
// passes the read stage and then the output register: the store is a ram with a
// registered read, so a transmit request reads in the cycle it is taken and the
// byte is moved to the output register when the read stage advances. After
// reset the store is swept to zero, one byte per cycle, over all REG_COUNT *
// BYTES_PER_REG bytes (512 at the default size); no item is taken during that pass.
module i2c_target_register_bank_core
    import i2ctrb_pkg::*;
#(
    parameter int REG_COUNT     = 128,
    parameter int BYTES_PER_REG = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    localparam int STORE_SIZE = REG_COUNT * BYTES_PER_REG;
    localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

    logic              accept;
    t_mem_op           mem_op;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_wdata;
    logic [7:0]        rd_data;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              s1_move;

    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_s1_valid;
    logic              r_s1_tx;
    logic              r_s1_mem;
    logic              r_out_valid;
    t_out_item         r_out_item;

    assign s1_move    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_clr_busy || (r_s1_valid && !s1_move);
    assign accept     = i_in_valid && !o_in_stall;

    i2ctrb_ctrl #(
        .REG_COUNT     (REG_COUNT),
        .BYTES_PER_REG (BYTES_PER_REG),
        .ADDR_W        (ADDR_W)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .o_op     (mem_op),
        .o_addr   (mem_addr),
        .o_wdata  (mem_wdata)
    );

    assign ram_we    = r_clr_busy || mem_op.wr_en;
    assign ram_waddr = r_clr_busy ? r_clr_addr : mem_addr;
    assign ram_wdata = r_clr_busy ? 8'd0 : mem_wdata;

    i2ctrb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_SIZE)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (mem_op.rd_en),
        .i_rd_addr (mem_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(STORE_SIZE - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= r_s1_valid;
            end
        end
        if (accept) begin
            r_s1_tx  <= mem_op.tx_req;
            r_s1_mem <= mem_op.rd_en;
        end
        if (r_s1_valid && s1_move) begin
            r_out_item.tx_valid <= r_s1_tx;
            r_out_item.tx_byte  <= r_s1_mem ? rd_data : 8'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // a byte that is not a transmit is always zero
    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.tx_valid |-> o_out_item.tx_byte == 8'd0)
        else $error("non-transmit result carries a data byte");

    // every accepted item enters the read stage
    a_s1_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted item lost before read stage");

    // a held read stage keeps its item
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_move |=> r_s1_valid && $stable(r_s1_tx) && $stable(r_s1_mem))
        else $error("read stage dropped or changed a held item");

    // no item reaches the store while it is being swept
    a_clr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !mem_op.wr_en && !mem_op.rd_en)
        else $error("store access during clearing pass");

endmodule

// File: tb/i2c_target_register_bank_core_tb.sv
// ----------------------------------------------------------------------------
// i2c_target_register_bank_core_tb
// self-checking bench for the i2c target register bank: bus events go in as
// items, a local copy of the targets, byte index and register bytes predicts
// each result, and every result is checked in order against that prediction
// ----------------------------------------------------------------------------
module i2c_target_register_bank_core_tb;
    import i2ctrb_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    t_in_item  i_in_item;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;
    logic      i_out_stall;

    // local copy of the bank
    logic       wr_sel_valid;
    logic [6:0] wr_sel;
    logic       rd_sel_valid;
    logic [6:0] rd_sel;
    logic [1:0] byte_pos;
    logic [7:0] reg_bytes [512];

    t_out_item expected_tx_q [$];
    int        error_count = 0;
    int        cycle_count = 0;
    int        busy_events = 0;
    logic      in_gaps_on  = 1'b1;
    logic      out_stall_on = 1'b1;

    i2c_target_register_bank_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("i2c_target_register_bank_core_tb failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= out_stall_on && ($urandom_range(0, 99) < 8);
    end

    function automatic t_out_item predict_bus_event(t_in_item it);
        t_out_item res;
        res = '0;
        case (it.kind)
            KIND_RX_BYTE: begin
                if (!wr_sel_valid) begin
                    if (it.rx_byte[0]) begin
                        wr_sel       = it.rx_byte[7:1];
                        wr_sel_valid = 1'b1;
                    end else begin
                        rd_sel       = it.rx_byte[7:1];
                        rd_sel_valid = 1'b1;
                    end
                end else begin
                    reg_bytes[{wr_sel, byte_pos}] = it.rx_byte;
                    if (byte_pos == 2'd3) begin
                        wr_sel_valid = 1'b0;
                        byte_pos     = 2'd0;
                    end else begin
                        byte_pos = byte_pos + 2'd1;
                    end
                end
            end
            KIND_TX_REQ: begin
                res.tx_valid = 1'b1;
                if (rd_sel_valid) begin
                    res.tx_byte = reg_bytes[{rd_sel, byte_pos}];
                    byte_pos    = byte_pos + 2'd1;
                end
            end
            KIND_STOP: begin
                if (byte_pos != 2'd0) begin
                    wr_sel_valid = 1'b0;
                    rd_sel_valid = 1'b0;
                    wr_sel       = '0;
                    rd_sel       = '0;
                    byte_pos     = 2'd0;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_event(input logic [1:0] kind, input logic [7:0] rx);
        t_in_item it;
        it.kind    = kind;
        it.rx_byte = rx;
        while (in_gaps_on && ($urandom_range(0, 99) < 8)) begin
            i_in_valid <= 1'b0;
            i_in_item  <= t_in_item'($urandom);
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_tx_q.push_back(predict_bus_event(it));
        if (kind != KIND_OTHER) busy_events++;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_tx_q.size() == 0) begin
                $display("%0t: unexpected item, expected none, got byte %02h valid %0b",
                         $time, o_out_item.tx_byte, o_out_item.tx_valid);
                error_count++;
            end else begin
                want = expected_tx_q.pop_front();
                if (o_out_item.tx_byte !== want.tx_byte) begin
                    $display("%0t: tx_byte mismatch, expected %02h, got %02h",
                             $time, want.tx_byte, o_out_item.tx_byte);
                    error_count++;
                end
                if (o_out_item.tx_valid !== want.tx_valid) begin
                    $display("%0t: tx_valid mismatch, expected %0b, got %0b",
                             $time, want.tx_valid, o_out_item.tx_valid);
                    error_count++;
                end
            end
        end
    end

    // no target held: transmit gives zero, nack and stop at index zero do nothing
    task automatic test_idle_events();
        send_event(KIND_TX_REQ, 8'h00);
        send_event(KIND_OTHER, 8'hff);
        send_event(KIND_STOP, 8'h00);
        send_event(KIND_TX_REQ, 8'hff);
    endtask

    // write the top and bottom registers with extreme bytes, read them back
    task automatic test_write_read_back();
        send_event(KIND_RX_BYTE, 8'hff);
        send_event(KIND_RX_BYTE, 8'h00);
        send_event(KIND_RX_BYTE, 8'hff);
        send_event(KIND_RX_BYTE, 8'ha5);
        send_event(KIND_RX_BYTE, 8'h5a);
        send_event(KIND_RX_BYTE, 8'h01);
        send_event(KIND_RX_BYTE, 8'h80);
        send_event(KIND_RX_BYTE, 8'h7f);
        send_event(KIND_RX_BYTE, 8'h3c);
        send_event(KIND_RX_BYTE, 8'hc3);
        send_event(KIND_RX_BYTE, 8'hfe);
        repeat (5) send_event(KIND_TX_REQ, 8'h00);
        send_event(KIND_STOP, 8'h00);
        send_event(KIND_RX_BYTE, 8'h00);
        repeat (4) send_event(KIND_TX_REQ, 8'h00);
    endtask

    // transmit moves the index a write is using; stop mid-register clears all
    task automatic test_shared_index();
        send_event(KIND_RX_BYTE, 8'h02);
        send_event(KIND_RX_BYTE, 8'h03);
        send_event(KIND_RX_BYTE, 8'h11);
        send_event(KIND_TX_REQ, 8'h00);
        send_event(KIND_RX_BYTE, 8'h22);
        send_event(KIND_STOP, 8'h00);
        send_event(KIND_TX_REQ, 8'h00);
        send_event(KIND_RX_BYTE, 8'h02);
        repeat (4) send_event(KIND_TX_REQ, 8'h00);
    endtask

    task automatic test_random_traffic(input int n_events);
        int         start;
        int         pick;
        int         n;
        logic [6:0] reg_no;
        start = busy_events;
        while (busy_events - start < n_events) begin
            in_gaps_on   = !((busy_events - start) inside {[150:260]});
            out_stall_on = in_gaps_on;
            pick   = $urandom_range(0, 99);
            reg_no = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 7));
            if (pick < 40) begin
                send_event(KIND_RX_BYTE, {reg_no, 1'b1});
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 4;
                repeat (n) begin
                    if ($urandom_range(0, 19) == 0) send_event(KIND_TX_REQ, 8'($urandom));
                    send_event(KIND_RX_BYTE, 8'($urandom));
                end
                if ($urandom_range(0, 2) == 0) send_event(KIND_STOP, 8'($urandom));
            end else if (pick < 75) begin
                send_event(KIND_RX_BYTE, {reg_no, 1'b0});
                repeat ($urandom_range(1, 6)) send_event(KIND_TX_REQ, 8'($urandom));
                if ($urandom_range(0, 9) < 7) send_event(KIND_STOP, 8'($urandom));
            end else begin
                send_event(2'($urandom), 8'($urandom));
            end
        end
        in_gaps_on   = 1'b1;
        out_stall_on = 1'b1;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_item    = '0;
        i_out_stall  = 1'b0;
        wr_sel_valid = 1'b0;
        wr_sel       = '0;
        rd_sel_valid = 1'b0;
        rd_sel       = '0;
        byte_pos     = '0;
        foreach (reg_bytes[i]) reg_bytes[i] = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_idle_events();
        test_write_read_back();
        test_shared_index();
        test_random_traffic(450);

        i_in_valid <= 1'b0;
        while (expected_tx_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("i2c_target_register_bank_core_tb passed");
        end else begin
            $display("i2c_target_register_bank_core_tb failed");
        end
        $finish;
    end

endmodule
